// ----- src/rstree_pkg.sv -----
// Package for the range sum tree: sizes, node address types and the
// request word from the tree controller to the node store.
// No dependencies.
`timescale 1ns / 1ps

package rstree_pkg;

  // Table geometry
  localparam int unsigned Leaves    = 1024;
  localparam int unsigned NodeCount = 2 * Leaves;
  localparam int unsigned NodeW     = $clog2(NodeCount);

  // Field widths
  localparam int unsigned SumW  = 32;
  localparam int unsigned PosW  = 10;
  localparam int unsigned RbW   = 11;
  localparam int unsigned CmdW  = 1;
  localparam int unsigned InTdataW = 56;

  // Command codes
  localparam logic [CmdW-1:0] CmdAdd   = 1'b0;
  localparam logic [CmdW-1:0] CmdQuery = 1'b1;

  typedef logic [NodeW-1:0] node_addr_t;
  typedef logic [NodeW:0]   node_idx_t;   // one bit more, holds NodeCount itself
  typedef logic [SumW-1:0]  sum_t;

  // Access request to the node store: one write port, two read ports
  typedef struct packed {
    logic       we;
    node_addr_t waddr;
    sum_t       wdata;
    node_addr_t raddr_a;
    node_addr_t raddr_b;
  } ram_req_t;

endpackage

// ----- src/range_sum_tree_top.sv -----
// Top level of the range sum tree: command sequencer around the node store.
// Depends on rstree_pkg and rstree_ram.
//
//   port group   dir  word contents (lowest bit first)
//   s_axis_*     in   tuser: cmd; tdata: position[9:0], right_bound[20:10],
//                     delta[52:21], zero pad to 56 bits
//   m_axis_*     out  tdata: range_sum[31:0]; one word per query, none per add
//
// An add takes one registered read of the leaf, then one sibling read and parent
// write per tree level on the store's ports.
// A query walks both range bounds together, one level a cycle, using the store's
// two read ports; a last walk step collects the last level and S_QDONE hands
// the sum to the output register.
// After reset a clearing pass writes zero to all NodeCount (2048) entries,
// one a cycle; no word is accepted until it ends.
// A finished query waits in the output register; the next command is taken
// meanwhile, and a later query holds its result until the register frees.
`timescale 1ns / 1ps

module range_sum_tree_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rstree_pkg::InTdataW-1:0]   s_axis_tdata,  // position, right_bound, delta, pad
  input  logic                              s_axis_tuser,  // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata   // range_sum
);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LEAF  = 3'd2;
  localparam logic [2:0] S_UP    = 3'd3;
  localparam logic [2:0] S_QWALK = 3'd4;
  localparam logic [2:0] S_QDONE = 3'd5;

  localparam int unsigned NodeW = rstree_pkg::NodeW;
  localparam int unsigned PosW  = rstree_pkg::PosW;
  localparam int unsigned RbW   = rstree_pkg::RbW;
  localparam int unsigned SumW  = rstree_pkg::SumW;

  logic [2:0]                state_q, state_d;
  rstree_pkg::node_addr_t    clr_q, clr_d;
  rstree_pkg::node_addr_t    node_q, node_d;
  rstree_pkg::sum_t          cur_q, cur_d;
  rstree_pkg::sum_t          delta_q, delta_d;
  rstree_pkg::node_idx_t     lo_q, lo_d;
  rstree_pkg::node_idx_t     hi_q, hi_d;
  logic                      pa_q, pa_d;
  logic                      pb_q, pb_d;
  rstree_pkg::sum_t          acc_q, acc_d;
  logic                      out_valid_q, out_valid_d;
  rstree_pkg::sum_t          out_data_q, out_data_d;

  rstree_pkg::ram_req_t      ram_req;
  rstree_pkg::sum_t          rd_a, rd_b;

  // Input word fields
  logic                      in_cmd;
  logic [PosW-1:0]           in_pos;
  logic [RbW-1:0]            in_rb;
  rstree_pkg::sum_t          in_delta;
  logic                      in_acc;

  assign in_cmd   = s_axis_tuser;
  assign in_pos   = s_axis_tdata[PosW-1:0];
  assign in_rb    = s_axis_tdata[PosW+RbW-1:PosW];
  assign in_delta = s_axis_tdata[PosW+RbW+SumW-1:PosW+RbW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Walk helpers
  logic [31:0]               rb_clamp;
  logic                      out_free;
  logic                      fa, fb;
  rstree_pkg::node_idx_t     lo_n, hi_n, hi_m1;
  rstree_pkg::node_addr_t    parent;
  rstree_pkg::sum_t          add_a, add_b;

  assign rb_clamp = (32'(in_rb) > rstree_pkg::Leaves) ? 32'(rstree_pkg::Leaves)
                                                      : 32'(in_rb);
  assign out_free = ~out_valid_q | m_axis_tready;
  assign fa       = lo_q[0];
  assign fb       = hi_q[0];
  assign lo_n     = lo_q + (NodeW+1)'(fa);
  assign hi_n     = hi_q - (NodeW+1)'(fb);
  assign hi_m1    = hi_q - (NodeW+1)'(1);
  assign parent   = node_q >> 1;
  assign add_a    = pa_q ? rd_a : '0;
  assign add_b    = pb_q ? rd_b : '0;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    cur_d       = cur_q;
    delta_d     = delta_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    ram_req     = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_q;
        ram_req.wdata = '0;
        clr_d         = clr_q + NodeW'(1);
        if (clr_q == NodeW'(rstree_pkg::NodeCount - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == rstree_pkg::CmdAdd) begin
            // out-of-table adds are dropped
            if (32'(in_pos) < rstree_pkg::Leaves) begin
              node_d          = NodeW'(32'(in_pos) + rstree_pkg::Leaves);
              ram_req.raddr_a = NodeW'(32'(in_pos) + rstree_pkg::Leaves);
              delta_d         = in_delta;
              state_d         = S_LEAF;
            end
          end else begin
            hi_d  = (NodeW+1)'(rb_clamp + rstree_pkg::Leaves);
            // empty range collapses to lo == hi
            if (32'(in_pos) < rb_clamp) begin
              lo_d = (NodeW+1)'(32'(in_pos) + rstree_pkg::Leaves);
            end else begin
              lo_d = (NodeW+1)'(rb_clamp + rstree_pkg::Leaves);
            end
            acc_d   = '0;
            pa_d    = 1'b0;
            pb_d    = 1'b0;
            state_d = S_QWALK;
          end
        end
      end
      S_LEAF: begin
        // leaf word arrives: update it, fetch its sibling
        cur_d           = rd_a + delta_q;
        ram_req.we      = 1'b1;
        ram_req.waddr   = node_q;
        ram_req.wdata   = rd_a + delta_q;
        ram_req.raddr_a = node_q ^ NodeW'(1);
        state_d         = S_UP;
      end
      S_UP: begin
        // sibling arrives: write the parent, fetch the parent's sibling
        cur_d           = cur_q + rd_a;
        ram_req.we      = 1'b1;
        ram_req.waddr   = parent;
        ram_req.wdata   = cur_q + rd_a;
        ram_req.raddr_a = parent ^ NodeW'(1);
        node_d          = parent;
        if (parent == NodeW'(1)) begin
          state_d = S_IDLE;
        end
      end
      S_QWALK: begin
        // collect the words fetched on the previous level
        acc_d = acc_q + add_a + add_b;
        if (lo_q < hi_q) begin
          ram_req.raddr_a = lo_q[NodeW-1:0];
          ram_req.raddr_b = hi_m1[NodeW-1:0];
          pa_d            = fa;
          pb_d            = fb;
          lo_d            = lo_n >> 1;
          hi_d            = hi_n >> 1;
        end else begin
          pa_d    = 1'b0;
          pb_d    = 1'b0;
          state_d = S_QDONE;
        end
      end
      S_QDONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      pa_q        <= 1'b0;
      pb_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    cur_q      <= cur_d;
    delta_q    <= delta_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  // Node store
  rstree_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_up_node_internal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP) |-> (node_q >= NodeW'(2)))
    else $error("upward walk below the root level");

  a_walk_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QWALK) |-> (lo_q <= hi_q))
    else $error("query bounds crossed");

  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == S_QDONE))
    else $error("result word without a finished query");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> (ram_req.we || state_q == S_IDLE))
    else $error("clearing pass interrupted");

endmodule

// ----- src/rstree_ram.sv -----
// Node store of the range sum tree: NodeCount words, one write port and
// two read ports, read data registered.
// Depends on rstree_pkg.
`timescale 1ns / 1ps

module rstree_ram (
  input  logic               clk_i,
  input  rstree_pkg::ram_req_t req_i,
  output rstree_pkg::sum_t   rd_a_o,
  output rstree_pkg::sum_t   rd_b_o
);

  rstree_pkg::sum_t mem [rstree_pkg::NodeCount];
  rstree_pkg::sum_t rd_a_q;
  rstree_pkg::sum_t rd_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[req_i.raddr_a];
    rd_b_q <= mem[req_i.raddr_b];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for range_sum_tree_top: directed table, then random adds and queries.
// Uses its own model of the node sums to predict query results not pinned in the directed table.
// Depends on rstree_pkg and the range_sum_tree_top RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CmdW = rstree_pkg::CmdW;
  localparam int unsigned PosW = rstree_pkg::PosW;
  localparam int unsigned RbW  = rstree_pkg::RbW;
  localparam int unsigned SumW = rstree_pkg::SumW;

  localparam int unsigned ScriptRows  = 25;
  localparam int unsigned RandomWords = 750;
  localparam int unsigned CalmFrom    = 650;  // no idling from here on

  // One directed command; sum is only used when pinned is set
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] pos;
    logic [RbW-1:0]  rb;
    logic [SumW-1:0] delta;
    logic            pinned;
    logic [SumW-1:0] sum;
  } tree_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // position, right_bound, delta, pad
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // range_sum

  // Shadow copy of the node store and the sums still owed by the block
  rstree_pkg::sum_t shadow_nodes [rstree_pkg::NodeCount];
  rstree_pkg::sum_t sums_due [$];
  int unsigned      fail_count;
  bit               calm;

  range_sum_tree_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Add to one leaf, then refresh each ancestor up to the root
  function automatic void shadow_add(int unsigned leaf, rstree_pkg::sum_t amount);
    int unsigned n;
    if (leaf >= rstree_pkg::Leaves) return;
    n = leaf + rstree_pkg::Leaves;
    shadow_nodes[n] = shadow_nodes[n] + amount;
    while (n > 1) begin
      shadow_nodes[n >> 1] = shadow_nodes[n] + shadow_nodes[n ^ 1];
      n = n >> 1;
    end
  endfunction

  // Sum of leaves in [lo, hi), hi clamped to the table size
  function automatic rstree_pkg::sum_t shadow_range_sum(int unsigned lo, int unsigned hi);
    rstree_pkg::sum_t acc;
    acc = '0;
    if (hi > rstree_pkg::Leaves) hi = rstree_pkg::Leaves;
    if (lo >= hi) return acc;
    lo += rstree_pkg::Leaves;
    hi += rstree_pkg::Leaves;
    while (lo < hi) begin
      if (lo[0]) begin
        acc = acc + shadow_nodes[lo];
        lo++;
      end
      if (hi[0]) begin
        hi--;
        acc = acc + shadow_nodes[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return acc;
  endfunction

  // Offer one word at the falling edge, hold it until taken, then update the shadow
  task automatic send_word(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos, logic [RbW-1:0] rb,
                           logic [SumW-1:0] delta, bit pinned,
                           rstree_pkg::sum_t pinned_sum);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, delta, rb, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == rstree_pkg::CmdAdd) begin
      shadow_add(pos, delta);
    end else begin
      sums_due.push_back(pinned ? pinned_sum : shadow_range_sum(pos, rb));
    end
    @(negedge clk_i);
  endtask

  // Hold the sender back until every owed sum has come out
  task automatic drain_sums();
    s_axis_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver back-pressure in random bursts
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    rstree_pkg::sum_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sums_due.size() == 0) begin
        $error("range_sum: unexpected word 0x%08h with no query pending", m_axis_tdata);
        fail_count++;
      end else begin
        want = sums_due.pop_front();
        if (m_axis_tdata !== want) begin
          $error("range_sum: expected 0x%08h, got 0x%08h", want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    tree_cmd_t       script [ScriptRows];
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] pos;
    logic [RbW-1:0]  rb;
    logic [SumW-1:0] delta;
    int unsigned     pick;

    // fresh table, wrap on leaf 1023, wrap of the total, clamping and empty ranges
    script = '{
      '{rstree_pkg::CmdQuery, 10'd0,    11'd1024, 32'h0,         1'b1, 32'h0000_0000},
      '{rstree_pkg::CmdQuery, 10'd0,    11'd2047, 32'h0,         1'b1, 32'h0000_0000},
      '{rstree_pkg::CmdAdd,   10'd0,    11'd0,    32'h7fff_ffff, 1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd0,    11'd1,    32'h0,         1'b1, 32'h7fff_ffff},
      '{rstree_pkg::CmdAdd,   10'd0,    11'd2047, 32'h0000_0001, 1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd0,    11'd1,    32'h0,         1'b1, 32'h8000_0000},
      '{rstree_pkg::CmdAdd,   10'd1023, 11'd0,    32'h8000_0000, 1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd1023, 11'd1024, 32'h0,         1'b1, 32'h8000_0000},
      '{rstree_pkg::CmdQuery, 10'd0,    11'd1024, 32'h0,         1'b1, 32'h0000_0000},
      '{rstree_pkg::CmdAdd,   10'd1023, 11'd0,    32'hffff_ffff, 1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd0,    11'd2047, 32'hffff_ffff, 1'b1, 32'hffff_ffff},
      '{rstree_pkg::CmdQuery, 10'd512,  11'd512,  32'h0,         1'b1, 32'h0000_0000},
      '{rstree_pkg::CmdQuery, 10'd1023, 11'd0,    32'h0,         1'b1, 32'h0000_0000},
      '{rstree_pkg::CmdQuery, 10'd1023, 11'd1500, 32'h0,         1'b1, 32'h7fff_ffff},
      '{rstree_pkg::CmdAdd,   10'd341,  11'd0,    32'h1234_5678, 1'b0, 32'h0},
      '{rstree_pkg::CmdAdd,   10'd682,  11'd0,    32'hedcb_a988, 1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd1,    11'd1023, 32'h0,         1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd341,  11'd342,  32'h0,         1'b0, 32'h0},
      '{rstree_pkg::CmdAdd,   10'd512,  11'd0,    32'h0000_0005, 1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd511,  11'd513,  32'h0,         1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd0,    11'd1024, 32'h0,         1'b0, 32'h0},
      '{rstree_pkg::CmdAdd,   10'd1,    11'd0,    32'haaaa_aaaa, 1'b0, 32'h0},
      '{rstree_pkg::CmdAdd,   10'd1022, 11'd0,    32'h5555_5555, 1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd1,    11'd1023, 32'h0,         1'b0, 32'h0},
      '{rstree_pkg::CmdQuery, 10'd0,    11'd2047, 32'h0,         1'b0, 32'h0}
    };

    calm          = 1'b0;
    fail_count    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = rstree_pkg::CmdAdd;
    s_axis_tdata  = '0;
    foreach (shadow_nodes[n]) shadow_nodes[n] = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (script[r]) begin
      send_word(script[r].cmd, script[r].pos, script[r].rb, script[r].delta,
                script[r].pinned, script[r].sum);
    end
    drain_sums();

    // Random commands: a hot window of leaves keeps sums busy, with some wide deltas
    for (int unsigned w = 0; w < RandomWords; w++) begin
      calm = (w >= CalmFrom);
      if (w == 300) drain_sums();
      if ($urandom_range(0, 99) < 45) begin
        cmd = rstree_pkg::CmdAdd;
        pos = ($urandom_range(0, 1) == 0) ? PosW'($urandom_range(0, 1023))
                                          : PosW'($urandom_range(480, 560));
        delta = ($urandom_range(0, 3) == 0) ? $urandom()
                                            : SumW'($urandom_range(0, 200)) - 32'd100;
        rb = RbW'($urandom_range(0, 2047));
      end else begin
        cmd   = rstree_pkg::CmdQuery;
        delta = $urandom();
        pos   = PosW'($urandom_range(0, 1023));
        pick  = $urandom_range(0, 9);
        if (pick < 7)       rb = RbW'(pos + $urandom_range(0, 1024 - pos));
        else if (pick == 7) rb = RbW'($urandom_range(0, 2047));
        else if (pick == 8) rb = RbW'($urandom_range(1025, 2047));
        else                rb = RbW'($urandom_range(0, pos));
      end
      send_word(cmd, pos, rb, delta, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // Let the last sums out, then wait for trailing adds
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
